FILE: sv/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// constants shared by the primality tester modules
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int unsigned WIDTH = 64;

    typedef logic [WIDTH-1:0] t_word;

    localparam t_word SMALL_LIMIT = 64'd4759123141;

    // witness table: entries 0..2 small set, 3..9 large set
    function automatic t_word witness(input logic [3:0] idx);
        t_word w;
        case (idx)
            4'd0:    w = 64'd2;
            4'd1:    w = 64'd7;
            4'd2:    w = 64'd61;
            4'd3:    w = 64'd2;
            4'd4:    w = 64'd325;
            4'd5:    w = 64'd9375;
            4'd6:    w = 64'd28178;
            4'd7:    w = 64'd450775;
            4'd8:    w = 64'd9780504;
            4'd9:    w = 64'd1795265022;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

FILE: sv/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod
// bit-serial modular multiplier, one double-and-add step per cycle
// ----------------------------------------------------------------------------
module mrpt_mulmod (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  mrpt_pkg::t_word i_a,
    input  mrpt_pkg::t_word i_b,
    input  mrpt_pkg::t_word i_m,
    output logic          o_done,
    output mrpt_pkg::t_word o_p
);
    logic            r_busy, n_busy;
    logic [5:0]      r_cnt, n_cnt;
    mrpt_pkg::t_word r_acc, n_acc;
    mrpt_pkg::t_word r_a, r_b, r_m, n_a, n_b, n_m;
    logic            r_done, n_done;
    logic [64:0]     dbl, dsub, add, asub;
    mrpt_pkg::t_word acc1;

    always_comb begin
        dbl  = {r_acc, 1'b0};
        dsub = dbl - {1'b0, r_m};
        acc1 = dsub[64] ? dbl[63:0] : dsub[63:0];
        add  = {1'b0, acc1} + {1'b0, r_a};
        asub = add - {1'b0, r_m};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        n_done = 1'b0;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = 6'd63;
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
        end else if (r_busy) begin
            n_acc = r_b[63] ? (asub[64] ? add[63:0] : asub[63:0]) : acc1;
            n_b   = {r_b[62:0], 1'b0};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

FILE: sv/miller_rabin_prime_test_64.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64
// deterministic miller-rabin primality test on 64-bit unsigned numbers
// ----------------------------------------------------------------------------
// trivial numbers strobe in the cycle after the accepting edge, large primes run all
// seven witnesses; one item at a time, busy while worked
// every multiply goes through one shared bit-serial mulmod
// result is a one-cycle strobe, receiver cannot stall, next item taken in the cycle after
// synchronous active-low reset returns the sequencer to idle
module miller_rabin_prime_test_64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_number,
    output logic        o_valid,
    output logic        o_prime
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPLIT = 4'd1;
    localparam logic [3:0] S_WIT   = 4'd2;
    localparam logic [3:0] S_PMUL  = 4'd3; // x = x*a
    localparam logic [3:0] S_PWAIT = 4'd4;
    localparam logic [3:0] S_SMUL  = 4'd5; // a = a*a
    localparam logic [3:0] S_SWAIT = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_QMUL  = 4'd8; // x = x*x
    localparam logic [3:0] S_QWAIT = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]      r_st, n_st;
    mrpt_pkg::t_word r_n, n_n, r_d, n_d, r_e, n_e, r_a, n_a, r_x, n_x;
    logic [5:0]      r_s, n_s, r_r, n_r;
    logic [3:0]      r_wi, n_wi, r_wend, n_wend;
    logic            r_res, n_res;
    logic            mm_start;
    mrpt_pkg::t_word mm_a, mm_b, mm_p, w, nm1;
    logic            mm_done;

    mrpt_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (r_n),
        .o_done  (mm_done),
        .o_p     (mm_p)
    );

    assign w   = mrpt_pkg::witness(r_wi);
    assign nm1 = r_n - 64'd1;

    always_comb begin
        n_st = r_st; n_n = r_n; n_d = r_d; n_e = r_e; n_a = r_a; n_x = r_x;
        n_s = r_s; n_r = r_r; n_wi = r_wi; n_wend = r_wend; n_res = r_res;
        mm_start = 1'b0;
        mm_a = r_x;
        mm_b = r_a;
        case (r_st)
            S_IDLE: begin
                if (start) begin
                    n_n = i_number;
                    n_d = i_number - 64'd1;
                    n_s = '0;
                    n_st = S_SPLIT;
                    // trivial cases decided up front
                    if (i_number < 64'd2) begin
                        n_res = 1'b0; n_st = S_DONE;
                    end else if (i_number < 64'd4) begin
                        n_res = 1'b1; n_st = S_DONE;
                    end else if (!i_number[0]) begin
                        n_res = 1'b0; n_st = S_DONE;
                    end
                    if (i_number < mrpt_pkg::SMALL_LIMIT) begin
                        n_wi = 4'd0; n_wend = 4'd3;
                    end else begin
                        n_wi = 4'd3; n_wend = 4'd10;
                    end
                end
            end
            S_SPLIT: begin
                // strip one trailing zero per cycle
                if (!r_d[0]) begin
                    n_d = {1'b0, r_d[63:1]};
                    n_s = r_s + 6'd1;
                end else begin
                    n_st = S_WIT;
                end
            end
            S_WIT: begin
                if (r_wi == r_wend || w >= r_n) begin
                    n_res = 1'b1; n_st = S_DONE;
                end else begin
                    n_a = w; n_e = r_d; n_x = 64'd1;
                    n_st = r_d[0] ? S_PMUL : S_SMUL;
                end
            end
            S_PMUL: begin
                mm_start = 1'b1; mm_a = r_x; mm_b = r_a; n_st = S_PWAIT;
            end
            S_PWAIT: if (mm_done) begin
                n_x = mm_p; n_st = S_SMUL;
            end
            S_SMUL: begin
                if (r_e[63:1] == '0) begin
                    n_st = S_CHK; n_r = 6'd1;
                end else begin
                    mm_start = 1'b1; mm_a = r_a; mm_b = r_a; n_st = S_SWAIT;
                end
            end
            S_SWAIT: if (mm_done) begin
                n_a = mm_p;
                n_e = {1'b0, r_e[63:1]};
                n_st = r_e[1] ? S_PMUL : S_SMUL;
            end
            S_CHK: begin
                if (r_x == nm1 || (r_r == 6'd1 && r_x == 64'd1)) begin
                    n_wi = r_wi + 4'd1; n_st = S_WIT;
                end else if (r_r >= r_s) begin
                    n_res = 1'b0; n_st = S_DONE;
                end else begin
                    n_st = S_QMUL;
                end
            end
            S_QMUL: begin
                mm_start = 1'b1; mm_a = r_x; mm_b = r_x; n_st = S_QWAIT;
            end
            S_QWAIT: if (mm_done) begin
                n_x = mm_p; n_r = r_r + 6'd1; n_st = S_CHK;
            end
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_n <= n_n; r_d <= n_d; r_e <= n_e; r_a <= n_a; r_x <= n_x;
        r_s <= n_s; r_r <= n_r; r_wi <= n_wi; r_wend <= n_wend; r_res <= n_res;
    end

    assign busy    = (r_st != S_IDLE);
    assign o_valid = (r_st == S_DONE);
    assign o_prime = r_res;
endmodule

FILE: bench/tb_miller_rabin_prime_test_64.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_prime_test_64
// self-checking bench for the 64-bit primality tester: directed corner
// numbers, then mostly fast random numbers with a few slow large ones,
// each result checked against an in-bench primality predictor
// ----------------------------------------------------------------------------
module tb_miller_rabin_prime_test_64;

    typedef mrpt_pkg::t_word t_word;

    localparam int unsigned HALF_PERIOD = 4;
    localparam int unsigned WATCHDOG_LIMIT = 250000;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned RANDOM_ITEMS = 90;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_word i_number = '0;
    logic  o_valid;
    logic  o_prime;

    // expected verdicts, oldest first, with the number for reporting
    t_word primality_numbers[$];
    bit    primality_verdicts[$];

    int unsigned error_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;

    miller_rabin_prime_test_64 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_number   (i_number),
        .o_valid    (o_valid),
        .o_prime    (o_prime)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // primality predictor
    // ------------------------------------------------------------------------

    // exact modular product through a 128-bit intermediate
    function automatic t_word mul_mod_exact(input t_word a, input t_word b, input t_word m);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return t_word'(prod % {64'd0, m});
    endfunction

    function automatic t_word pow_mod_exact(input t_word base, input t_word e, input t_word m);
        t_word acc;
        acc = 64'd1;
        while (e != 0) begin
            if (e[0])
                acc = mul_mod_exact(acc, base, m);
            base = mul_mod_exact(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // true if base a shows odd n composite, n-1 = d * 2^s
    function automatic bit base_proves_composite(input t_word n, input t_word a,
                                                 input t_word d, input int unsigned s);
        t_word x;
        x = pow_mod_exact(a, d, n);
        if (x == 64'd1 || x == n - 64'd1)
            return 1'b0;
        for (int unsigned r = 1; r < s; r++) begin
            x = mul_mod_exact(x, x, n);
            if (x == n - 64'd1)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit predict_prime(input t_word n);
        t_word bases_below[3] = '{64'd2, 64'd7, 64'd61};
        t_word bases_above[7] = '{64'd2, 64'd325, 64'd9375, 64'd28178,
                                  64'd450775, 64'd9780504, 64'd1795265022};
        t_word d;
        t_word a;
        int unsigned s;
        int unsigned count;
        if (n < 64'd2)
            return 1'b0;
        if (n == 64'd2 || n == 64'd3)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        d = n - 64'd1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        count = (n < mrpt_pkg::SMALL_LIMIT) ? 3 : 7;
        for (int unsigned i = 0; i < count; i++) begin
            a = (n < mrpt_pkg::SMALL_LIMIT) ? bases_below[i] : bases_above[i];
            // a base at or above n ends the search with a prime verdict
            if (a >= n)
                break;
            if (base_proves_composite(n, a, d, s))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // present one item and hold it until it is taken
    task automatic send_number(input t_word n);
        i_number <= n;
        start    <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        // taken at this edge
        primality_numbers.push_back(n);
        primality_verdicts.push_back(predict_prime(n));
    endtask

    // send with random bursts and gaps; zero-length gaps give back-to-back runs
    task automatic send_paced(input t_word n);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                start    <= 1'b0;
                i_number <= {$urandom, $urandom};
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_number(n);
    endtask

    // sender holds off until every outstanding verdict has come back
    task automatic drain_results;
        start <= 1'b0;
        @(posedge i_clk);
        while (primality_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // zero, one, two, three and the even shortcut
    task automatic test_trivial_numbers;
        send_paced(64'd0);
        send_paced(64'd1);
        send_paced(64'd2);
        send_paced(64'd3);
        send_paced(64'd4);
        send_paced(64'h8000_0000_0000_0000);
        send_paced(64'hFFFF_FFFF_FFFF_FFFE);
    endtask

    // small numbers where a base reaches or passes the number
    task automatic test_base_skip;
        send_paced(64'd5);
        send_paced(64'd7);
        send_paced(64'd9);
        send_paced(64'd59);
        send_paced(64'd61);
        send_paced(64'd63);
    endtask

    // strong pseudoprimes that fool some bases, and the set boundary
    task automatic test_pseudoprimes;
        send_paced(64'd2047);           // fools base 2
        send_paced(64'd3215031751);     // fools 2, 3, 5, 7
        send_paced(64'd4759123141);     // first number using the large set
        send_paced(64'd4759123139);     // just below the boundary
        send_paced(64'd1795265023);
    endtask

    // all-ones, the largest 64-bit prime and two alternating-bit patterns
    task automatic test_extremes;
        send_paced(64'hFFFF_FFFF_FFFF_FFFF);
        send_paced(64'hFFFF_FFFF_FFFF_FFC5);
        send_paced(64'h5555_5555_5555_5555);
        send_paced(64'hAAAA_AAAA_AAAA_AAAB);
        drain_results();
    endtask

    // mostly small odd numbers for speed, some wide ones, a few even ones
    task automatic test_random_numbers;
        t_word n;
        int unsigned pick;
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                n = {48'd0, 16'($urandom)} | 64'd1;
            else if (pick < 70)
                n = {32'd0, $urandom} | 64'd1;
            else if (pick < 90)
                n = {$urandom, $urandom} | 64'd1;
            else
                n = {$urandom, $urandom};
            send_paced(n);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // result checking and watchdog
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (primality_verdicts.size() == 0) begin
                error_count++;
                $display("unexpected result prime=%0b", o_prime);
            end else begin
                if (o_prime !== primality_verdicts[0]) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch n=%0d expected prime=%0b actual=%0b",
                                 primality_numbers[0], primality_verdicts[0], o_prime);
                end
                void'(primality_numbers.pop_front());
                void'(primality_verdicts.pop_front());
            end
        end
    end

    // counts cycles with neither an item taken nor a result given
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_trivial_numbers();
        test_base_skip();
        test_pseudoprimes();
        test_extremes();
        test_random_numbers();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (primality_verdicts.size() != 0)
            error_count++;
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: miller_rabin_prime_test_64.f
sv/mrpt_pkg.sv
sv/mrpt_mulmod.sv
sv/miller_rabin_prime_test_64.sv
bench/tb_miller_rabin_prime_test_64.sv
